[sv/prhp_pkg.sv]
package prhp_pkg;

  // Header field values
  localparam logic [7:0] VERSION_BYTE = 8'h01;
  localparam logic [7:0] CMD_PING     = 8'h00;
  localparam logic [7:0] CMD_CONNECT  = 8'h01;

  // Field widths
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned PORT_W = 16;
  localparam int unsigned ERR_W  = 3;

  // Master tdata: out_byte, port_value, error_code, zero fill to whole bytes
  localparam int unsigned M_FIELDS_W = BYTE_W + PORT_W + ERR_W;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // Parser phase, one-hot
  typedef enum logic [9:0] {
    PH_VERSION  = 10'b00_0000_0001,
    PH_COMMAND  = 10'b00_0000_0010,
    PH_UID_LEN  = 10'b00_0000_0100,
    PH_UID      = 10'b00_0000_1000,
    PH_ADDR_LEN = 10'b00_0001_0000,
    PH_ADDR     = 10'b00_0010_0000,
    PH_PORT_HI  = 10'b00_0100_0000,
    PH_PORT_LO  = 10'b00_1000_0000,
    PH_PAYLOAD  = 10'b01_0000_0000,
    PH_HALTED   = 10'b10_0000_0000
  } phase_e;

  // Result kind, carried on master tuser
  typedef enum logic [KIND_W-1:0] {
    K_HEADER  = 3'd0,
    K_ADDR    = 3'd1,
    K_PORT    = 3'd2,
    K_PAYLOAD = 3'd3,
    K_ERROR   = 3'd4,
    K_DROPPED = 3'd5
  } kind_e;

  // Error codes
  typedef enum logic [ERR_W-1:0] {
    E_NONE       = 3'd0,
    E_VERSION    = 3'd1,
    E_PING       = 3'd2,
    E_COMMAND    = 3'd3,
    E_EMPTY_ADDR = 3'd4
  } err_e;

endpackage

[sv/proxy_request_header_parser_unit.sv]
// Proxy request header parser. Takes one decrypted client byte per beat on the
// slave side (tdata = byte, tuser = start of a new session) and returns exactly
// one result beat per input beat on the master side: tuser gives the kind
// (header consumed, address byte, port ready, payload, error, dropped), tlast
// marks the final address byte, and tdata carries the address/payload byte,
// the assembled big-endian port and the error code. The block sustains one
// beat per cycle while the master side is ready; each byte passes through the
// input register and the result register around the combinational phase update.
// A header error is reported once; later bytes come out as dropped until a
// beat arrives with the new-session flag set.
module proxy_request_header_parser_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // slave side
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [prhp_pkg::BYTE_W-1:0]        s_axis_tdata_i,  // [7:0] in_byte
  input  logic                               s_axis_tuser_i,  // [0] new_session
  // master side
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [7:0] out_byte, [23:8] port_value, [26:24] fault code, [31:27] zero
  output logic [prhp_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tlast_o,  // addr_last
  output logic [prhp_pkg::KIND_W-1:0]        m_axis_tuser_o   // [2:0] kind
);

  // Input register
  logic                        in_valid_q;
  logic [prhp_pkg::BYTE_W-1:0] in_byte_q;
  logic                        in_new_q;

  // Parser state
  prhp_pkg::phase_e            phase_q, phase_d;
  logic [prhp_pkg::BYTE_W-1:0] left_q, left_d;
  logic [prhp_pkg::BYTE_W-1:0] port_hi_q, port_hi_d;

  // Result register
  logic                        out_valid_q;
  prhp_pkg::kind_e             kind_q, kind_d;
  logic [prhp_pkg::BYTE_W-1:0] obyte_q, obyte_d;
  logic                        last_q, last_d;
  logic [prhp_pkg::PORT_W-1:0] port_q, port_d;
  prhp_pkg::err_e              err_q, err_d;

  // Pipeline flow
  logic out_adv;
  logic in_adv;
  logic s_acc;

  assign out_adv         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || out_adv;
  assign s_acc           = s_axis_tvalid_i && s_axis_tready_o;
  assign in_adv          = out_adv;

  // Phase update for the byte in the input register
  prhp_pkg::phase_e            cur_phase;
  logic [prhp_pkg::BYTE_W-1:0] cur_left;
  logic [prhp_pkg::BYTE_W-1:0] cur_port_hi;
  logic [prhp_pkg::BYTE_W-1:0] left_dec;

  always_comb begin
    // a new session restarts at the version byte with cleared counters
    cur_phase   = in_new_q ? prhp_pkg::PH_VERSION : phase_q;
    cur_left    = in_new_q ? '0 : left_q;
    cur_port_hi = in_new_q ? '0 : port_hi_q;
    left_dec    = cur_left - 1'b1;

    phase_d   = cur_phase;
    left_d    = cur_left;
    port_hi_d = cur_port_hi;
    kind_d    = prhp_pkg::K_HEADER;
    obyte_d   = '0;
    last_d    = 1'b0;
    port_d    = '0;
    err_d     = prhp_pkg::E_NONE;

    unique case (cur_phase)
      prhp_pkg::PH_VERSION: begin
        if (in_byte_q != prhp_pkg::VERSION_BYTE) begin
          kind_d  = prhp_pkg::K_ERROR;
          err_d   = prhp_pkg::E_VERSION;
          phase_d = prhp_pkg::PH_HALTED;
        end else begin
          phase_d = prhp_pkg::PH_COMMAND;
        end
      end
      prhp_pkg::PH_COMMAND: begin
        if (in_byte_q == prhp_pkg::CMD_PING) begin
          kind_d  = prhp_pkg::K_ERROR;
          err_d   = prhp_pkg::E_PING;
          phase_d = prhp_pkg::PH_HALTED;
        end else if (in_byte_q == prhp_pkg::CMD_CONNECT) begin
          phase_d = prhp_pkg::PH_UID_LEN;
        end else begin
          kind_d  = prhp_pkg::K_ERROR;
          err_d   = prhp_pkg::E_COMMAND;
          phase_d = prhp_pkg::PH_HALTED;
        end
      end
      prhp_pkg::PH_UID_LEN: begin
        left_d  = in_byte_q;
        phase_d = (in_byte_q != '0) ? prhp_pkg::PH_UID : prhp_pkg::PH_ADDR_LEN;
      end
      prhp_pkg::PH_UID: begin
        left_d = left_dec;
        if (left_dec == '0) begin
          phase_d = prhp_pkg::PH_ADDR_LEN;
        end
      end
      prhp_pkg::PH_ADDR_LEN: begin
        if (in_byte_q == '0) begin
          kind_d  = prhp_pkg::K_ERROR;
          err_d   = prhp_pkg::E_EMPTY_ADDR;
          phase_d = prhp_pkg::PH_HALTED;
        end else begin
          left_d  = in_byte_q;
          phase_d = prhp_pkg::PH_ADDR;
        end
      end
      prhp_pkg::PH_ADDR: begin
        kind_d  = prhp_pkg::K_ADDR;
        obyte_d = in_byte_q;
        left_d  = left_dec;
        if (left_dec == '0) begin
          last_d  = 1'b1;
          phase_d = prhp_pkg::PH_PORT_HI;
        end
      end
      prhp_pkg::PH_PORT_HI: begin
        port_hi_d = in_byte_q;
        phase_d   = prhp_pkg::PH_PORT_LO;
      end
      prhp_pkg::PH_PORT_LO: begin
        kind_d  = prhp_pkg::K_PORT;
        port_d  = {cur_port_hi, in_byte_q};
        phase_d = prhp_pkg::PH_PAYLOAD;
      end
      prhp_pkg::PH_PAYLOAD: begin
        kind_d  = prhp_pkg::K_PAYLOAD;
        obyte_d = in_byte_q;
      end
      default: begin
        // halted after an error, or an unused code
        kind_d = prhp_pkg::K_DROPPED;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= prhp_pkg::PH_VERSION;
      left_q      <= '0;
      port_hi_q   <= '0;
    end else begin
      if (s_acc) begin
        in_valid_q <= 1'b1;
      end else if (in_adv) begin
        in_valid_q <= 1'b0;
      end
      if (out_adv) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        left_q      <= left_d;
        port_hi_q   <= port_hi_d;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_new_q  <= s_axis_tuser_i;
    end
    if (out_adv) begin
      kind_q  <= kind_d;
      obyte_q <= obyte_d;
      last_q  <= last_d;
      port_q  <= port_d;
      err_q   <= err_d;
    end
  end

  // Master side
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = kind_q;
  assign m_axis_tlast_o  = last_q;
  assign m_axis_tdata_o  = {{(prhp_pkg::M_TDATA_W - prhp_pkg::M_FIELDS_W){1'b0}},
                            err_q, port_q, obyte_q};

endmodule
